// ===== src/erc_pkg.sv =====
// shared constants, types and codes for the error range coalescer
package erc_pkg;

  localparam int SLOTS      = 21;
  localparam int WORD_BYTES = 8;
  localparam int ADDR_BITS  = 48;
  localparam int END_W      = ADDR_BITS + 1;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);

  // fixed item field widths
  localparam int MODE_W  = 2;
  localparam int FADDR_W = 48;
  localparam int SLOT_W  = 5;
  localparam int LEN_W   = 49;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ADDR_BITS-1:0] saddr_t;
  typedef logic [END_W-1:0]     eaddr_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_MRG,
    ST_MRG_RD,
    ST_MRG_WR,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    saddr_t start_val;
    eaddr_t end_val;
  } entry_t;

  typedef struct packed {
    logic   start_en;
    logic   end_en;
    idx_t   addr;
    entry_t data;
  } store_wr_t;

endpackage

// ===== src/error_range_coalescer.sv =====
// top level of the error range coalescer: sequencer, scan and merge datapath
//
// keeps a table of faulty address ranges [start, end) in SLOTS slots
// input channel (in_valid/in_ready) takes one item: mode, addr, slot
//   clear  : empties the table
//   read   : reports one slot (used flag, start, length)
//   insert : scans the slots in index order through one read port,
//            one slot a cycle, then grows a range or places the word in the
//            highest free slot
//   insert that fills the last spare slot: the closest pair is merged;
//            every slot pair goes through one shared gap unit, one pair a cycle
// in_ready is high only while the sequencer is idle, one item at a time
// output channel (out_valid/out_ready) carries one result item per input
// item from an output register; a new item is accepted while a result
// waits, and the sequencer holds its finished result until the register
// frees up when the receiver stalls
// reset clears the used flags and both channels; slot contents need none
module error_range_coalescer import erc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   mode,
  input  logic [FADDR_W-1:0]  addr,
  input  logic [SLOT_W-1:0]   slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                changed,
  output logic                slot_used,
  output logic [FADDR_W-1:0]  range_start,
  output logic [LEN_W-1:0]    range_length
);

  localparam idx_t LAST = IDX_W'(SLOTS - 1);

  state_t state, state_next;

  // item registers
  saddr_t a_reg;
  eaddr_t a_end;
  idx_t   slot_idx;
  logic   slot_ok;

  // table flags
  logic [SLOTS-1:0] used;

  // scan / pair counters
  idx_t pa, pb;
  logic issue_done;
  logic issue;

  // free slot search during scan
  logic       free_found;
  idx_t       free_idx;
  logic [CNT_W-1:0] used_cnt;

  // pipeline after the read ports
  logic   s1_valid, s1_ok;
  idx_t   s1_pa, s1_pb;
  logic   s2_valid;
  idx_t   s2_pa, s2_pb;
  eaddr_t gap, gap_reg;

  // closest pair so far
  logic   best_found;
  eaddr_t best_gap;
  idx_t   best_a, best_b;

  // result of the item in progress
  logic   res_changed, res_used;
  saddr_t res_start;
  eaddr_t res_len;

  // store ports
  store_wr_t wr;
  idx_t      rd_addr_a, rd_addr_b;
  entry_t    rd_a, rd_b;

  // slot tests on the data read during the scan
  logic contains, end_hit, start_hit;
  logic in_slot_ok;
  logic out_free;

  erc_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  erc_gap u_gap (
    .x   (rd_a),
    .y   (rd_b),
    .gap (gap)
  );

  assign in_ready   = (state == ST_IDLE);
  assign in_slot_ok = (32'(slot) < SLOTS);
  assign out_free   = !out_valid || out_ready;

  assign contains  = (rd_a.start_val <= a_reg) && (rd_a.end_val >= a_end);
  assign end_hit   = (rd_a.end_val == {1'b0, a_reg});
  assign start_hit = ({1'b0, rd_a.start_val} == a_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and store controls
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    rd_addr_a  = pa;
    rd_addr_b  = pb;
    wr         = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            MODE_INSERT: state_next = ST_SCAN;
            MODE_READ: begin
              // keep the read port inside the table for slot numbers past the end
              rd_addr_a  = in_slot_ok ? IDX_W'(slot) : '0;
              state_next = ST_RD_WAIT;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        issue = !issue_done;
        if (s1_valid && used[s1_pa] && (contains || end_hit || start_hit)) begin
          // first matching slot decides; a covered word leaves the table alone
          wr.addr = s1_pa;
          if (!contains && end_hit) begin
            wr.end_en       = 1'b1;
            wr.data.end_val = a_end;
          end else if (!contains) begin
            wr.start_en       = 1'b1;
            wr.data.start_val = a_reg;
          end
          state_next = ST_DONE;
        end else if (s1_valid && s1_pa == LAST) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (free_found) begin
          wr.start_en       = 1'b1;
          wr.end_en         = 1'b1;
          wr.addr           = free_idx;
          wr.data.start_val = a_reg;
          wr.data.end_val   = a_end;
          state_next = (used_cnt == CNT_W'(SLOTS - 1)) ? ST_MRG : ST_DONE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MRG: begin
        issue = !issue_done;
        if (issue_done && !s1_valid && !s2_valid) begin
          state_next = best_found ? ST_MRG_RD : ST_DONE;
        end
      end
      ST_MRG_RD: begin
        rd_addr_a  = best_a;
        rd_addr_b  = best_b;
        state_next = ST_MRG_WR;
      end
      ST_MRG_WR: begin
        // union of the pair goes into the lower slot
        wr.start_en       = 1'b1;
        wr.end_en         = 1'b1;
        wr.addr           = best_a;
        wr.data.start_val = (rd_b.start_val < rd_a.start_val) ? rd_b.start_val
                                                              : rd_a.start_val;
        wr.data.end_val   = (rd_b.end_val > rd_a.end_val) ? rd_b.end_val : rd_a.end_val;
        state_next = ST_DONE;
      end
      ST_RD_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    // read pipeline
    s1_valid <= issue;
    if (issue) begin
      s1_pa <= pa;
      s1_pb <= pb;
      s1_ok <= used[pa] && used[pb];
    end
    s2_valid <= s1_valid && s1_ok && (state == ST_MRG);
    s2_pa    <= s1_pa;
    s2_pb    <= s1_pb;
    gap_reg  <= gap;

    // strictly smaller gap wins, so ties keep the earlier pair
    if (s2_valid && (!best_found || gap_reg < best_gap)) begin
      best_found <= 1'b1;
      best_gap   <= gap_reg;
      best_a     <= s2_pa;
      best_b     <= s2_pb;
    end

    // slot and pair counters
    if (issue && state == ST_SCAN) begin
      if (!used[pa]) begin
        free_found <= 1'b1;
        free_idx   <= pa;
      end else begin
        used_cnt <= used_cnt + CNT_W'(1);
      end
      if (pa == LAST) begin
        issue_done <= 1'b1;
      end else begin
        pa <= pa + IDX_W'(1);
      end
    end
    if (issue && state == ST_MRG) begin
      if (pa == LAST - IDX_W'(1) && pb == LAST) begin
        issue_done <= 1'b1;
      end else if (pb == LAST) begin
        pa <= pa + IDX_W'(1);
        pb <= pa + IDX_W'(2);
      end else begin
        pb <= pb + IDX_W'(1);
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          a_reg       <= ADDR_BITS'(addr);
          a_end       <= END_W'(ADDR_BITS'(addr)) + END_W'(WORD_BYTES);
          slot_idx    <= IDX_W'(slot);
          slot_ok     <= in_slot_ok;
          pa          <= '0;
          issue_done  <= 1'b0;
          free_found  <= 1'b0;
          used_cnt    <= '0;
          res_changed <= 1'b0;
          res_used    <= 1'b0;
          res_start   <= '0;
          res_len     <= '0;
          if (mode == MODE_CLEAR) begin
            used <= '0;
          end
        end
      end
      ST_SCAN: begin
        if (s1_valid && used[s1_pa] && (contains || end_hit || start_hit)) begin
          res_changed <= !contains;
        end
      end
      ST_PLACE: begin
        if (free_found) begin
          used[free_idx] <= 1'b1;
          res_changed    <= 1'b1;
          pa             <= '0;
          pb             <= IDX_W'(1);
          issue_done     <= 1'b0;
          best_found     <= 1'b0;
        end
      end
      ST_MRG_WR: used[best_b] <= 1'b0;
      ST_RD_WAIT: begin
        if (slot_ok && used[slot_idx]) begin
          res_used  <= 1'b1;
          res_start <= rd_a.start_val;
          res_len   <= rd_a.end_val - {1'b0, rd_a.start_val};
        end
      end
      default: ;
    endcase

    // output register
    if (state == ST_DONE && out_free) begin
      out_valid    <= 1'b1;
      changed      <= res_changed;
      slot_used    <= res_used;
      range_start  <= FADDR_W'(res_start);
      range_length <= LEN_W'(res_len);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end

    if (rst) begin
      used       <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
      issue_done <= 1'b1;
      best_found <= 1'b0;
    end
  end

endmodule

// ===== src/erc_store.sv =====
// range table storage: one write port, two registered read ports
module erc_store import erc_pkg::*; (
  input  logic      clk,
  input  store_wr_t wr,
  input  idx_t      rd_addr_a,
  input  idx_t      rd_addr_b,
  output entry_t    rd_a,
  output entry_t    rd_b
);

  saddr_t start_mem [SLOTS];
  eaddr_t end_mem   [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.start_en) begin
      start_mem[wr.addr] <= wr.data.start_val;
    end
    if (wr.end_en) begin
      end_mem[wr.addr] <= wr.data.end_val;
    end
    rd_a.start_val <= start_mem[rd_addr_a];
    rd_a.end_val   <= end_mem[rd_addr_a];
    rd_b.start_val <= start_mem[rd_addr_b];
    rd_b.end_val   <= end_mem[rd_addr_b];
  end

endmodule

// ===== src/erc_gap.sv =====
// distance between two ranges, zero when they touch or overlap
module erc_gap import erc_pkg::*; (
  input  entry_t x,
  input  entry_t y,
  output eaddr_t gap
);

  logic [END_W:0] d_xy;
  logic [END_W:0] d_yx;

  assign d_xy = {2'b00, y.start_val} - {1'b0, x.end_val};
  assign d_yx = {2'b00, x.start_val} - {1'b0, y.end_val};

  always_comb begin
    if (!d_xy[END_W]) begin
      gap = d_xy[END_W-1:0];
    end else if (!d_yx[END_W]) begin
      gap = d_yx[END_W-1:0];
    end else begin
      gap = '0;
    end
  end

endmodule
